>>> rtl/arc_pkg.sv
package arc_pkg;

   localparam int unsigned DefaultTableDepth = 256;

   localparam logic [15:0] EtherTypeArp = 16'h0806;
   localparam logic [15:0] ArpOpRequest = 16'h0001;
   localparam logic [1:0]  OutOpNone    = 2'd0;
   localparam logic [1:0]  OutOpRequest = 2'd1;
   localparam logic [1:0]  OutOpReply   = 2'd2;
   localparam logic [47:0] BroadcastMac = 48'hFFFF_FFFF_FFFF;

   localparam logic [2:0] ActNone       = 3'd0;
   localparam logic [2:0] ActData       = 3'd1;
   localparam logic [2:0] ActArpRequest = 3'd2;
   localparam logic [2:0] ActArpReply   = 3'd3;
   localparam logic [2:0] ActDeliver    = 3'd4;

   // Classified work handed from the front end to the table engine.
   typedef struct packed {
      logic        is_send;
      logic        is_arp;
      logic        for_us;
      logic        is_request;
      logic        deliver;
      logic [31:0] key_ip;
      logic [47:0] sender_mac;
      logic [47:0] frame_src_mac;
   } job_type;

endpackage

>>> rtl/arc_front.sv
module arc_front
   import arc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_push,
   output logic          req_full,
   input  logic          req_func,
   input  logic [31:0]   req_dest_ip,
   input  logic [15:0]   req_ether_type,
   input  logic [47:0]   req_frame_dst_mac,
   input  logic [47:0]   req_frame_src_mac,
   input  logic [15:0]   req_arp_opcode,
   input  logic [47:0]   req_arp_sender_mac,
   input  logic [31:0]   req_arp_sender_ip,
   input  logic [31:0]   req_arp_target_ip,
   input  logic [47:0]   own_mac,
   input  logic [31:0]   own_ip,
   output logic          job_valid,
   output job_type       job,
   input  logic          job_take
);

   // Two-entry queue between classification and the table engine.
   job_type    q_ff [2];
   job_type    q_in;
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push_ok;

   assign req_full  = (cnt_ff == 2'd2);
   assign push_ok   = req_push && !req_full;
   assign job_valid = (cnt_ff != 2'd0);
   assign job       = q_ff[rd_ptr_ff];

   always_comb begin
      q_in.is_send       = !req_func;
      q_in.is_arp        = req_ether_type == EtherTypeArp;
      q_in.for_us        = req_arp_target_ip == own_ip;
      q_in.is_request    = req_arp_opcode == ArpOpRequest;
      q_in.deliver       = req_frame_dst_mac == own_mac;
      q_in.key_ip        = req_func ? req_arp_sender_ip : req_dest_ip;
      q_in.sender_mac    = req_arp_sender_mac;
      q_in.frame_src_mac = req_frame_src_mac;
      wr_ptr_in = wr_ptr_ff ^ push_ok;
      rd_ptr_in = rd_ptr_ff ^ job_take;
      cnt_in    = cnt_ff + {1'b0, push_ok} - {1'b0, job_take};
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_ff[wr_ptr_ff] <= q_in;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

>>> rtl/arc_engine.sv
module arc_engine
   import arc_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = DefaultTableDepth
)
(
   input  logic          clock,
   input  logic          reset,
   input  logic          job_valid,
   input  job_type       job,
   output logic          job_take,
   output logic          rsp_empty,
   input  logic          rsp_pop,
   output logic [2:0]    rsp_action,
   output logic [47:0]   rsp_out_dst_mac,
   output logic [1:0]    rsp_out_arp_op,
   output logic [47:0]   rsp_out_arp_target_mac,
   output logic [31:0]   rsp_out_arp_target_ip,
   output logic          rsp_retry,
   output logic          rsp_table_full
);

   localparam int unsigned IdxW = $clog2(TABLE_DEPTH);
   localparam int unsigned CntW = $clog2(TABLE_DEPTH + 1);

   localparam logic [2:0] StIdle   = 3'd0;
   localparam logic [2:0] StIssue  = 3'd1;
   localparam logic [2:0] StCheck  = 3'd2;
   localparam logic [2:0] StFinish = 3'd3;
   localparam logic [2:0] StOut    = 3'd4;

   logic [31:0] ip_mem  [TABLE_DEPTH];
   logic [47:0] mac_mem [TABLE_DEPTH];
   logic [31:0] ip_rd_ff;
   logic [47:0] mac_rd_ff;

   logic [2:0]      state_ff, state_in;
   logic [CntW-1:0] count_ff, count_in;
   logic [CntW-1:0] scan_ff, scan_in;
   logic [IdxW-1:0] rd_addr;
   logic            hit_ff, hit_in;
   logic [IdxW-1:0] hit_idx_ff, hit_idx_in;
   logic [47:0]     hit_mac_ff, hit_mac_in;
   job_type         job_ff;
   logic            wr_en;
   logic [IdxW-1:0] wr_addr;
   logic [31:0]     wr_ip;
   logic [47:0]     wr_mac;

   logic [2:0]  act_ff, act_in;
   logic [47:0] dmac_ff, dmac_in;
   logic [1:0]  op_ff, op_in;
   logic [47:0] tmac_ff, tmac_in;
   logic [31:0] tip_ff, tip_in;
   logic        retry_ff, retry_in, full_ff, full_in;
   logic        full_out_ff, full_out_in;

   assign job_take   = (state_ff == StIdle) && job_valid;
   assign rsp_empty  = (state_ff != StOut);
   assign rd_addr    = scan_ff[IdxW-1:0];
   assign rsp_action             = act_ff;
   assign rsp_out_dst_mac        = dmac_ff;
   assign rsp_out_arp_op         = op_ff;
   assign rsp_out_arp_target_mac = tmac_ff;
   assign rsp_out_arp_target_ip  = tip_ff;
   assign rsp_retry              = retry_ff;
   assign rsp_table_full         = full_out_ff;

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      scan_in     = scan_ff;
      hit_in      = hit_ff;
      hit_idx_in  = hit_idx_ff;
      hit_mac_in  = hit_mac_ff;
      act_in      = act_ff;
      dmac_in     = dmac_ff;
      op_in       = op_ff;
      tmac_in     = tmac_ff;
      tip_in      = tip_ff;
      retry_in    = retry_ff;
      full_in     = full_ff;
      full_out_in = full_out_ff;
      wr_en       = 1'b0;
      wr_addr     = hit_idx_ff;
      wr_ip       = job_ff.key_ip;
      wr_mac      = job_ff.sender_mac;
      case (state_ff)
         StIdle: begin
            scan_in = '0;
            hit_in  = 1'b0;
            if (job_valid) begin
               state_in = StIssue;
            end
         end
         StIssue: begin
            // Read address is issued here; data appears in the next cycle.
            if (scan_ff == count_ff || hit_ff) begin
               state_in = StFinish;
            end else begin
               state_in = StCheck;
            end
         end
         StCheck: begin
            if (ip_rd_ff == job_ff.key_ip) begin
               hit_in     = 1'b1;
               hit_idx_in = scan_ff[IdxW-1:0];
               hit_mac_in = mac_rd_ff;
            end
            scan_in  = scan_ff + 1'b1;
            state_in = StIssue;
         end
         StFinish: begin
            act_in   = ActNone;
            dmac_in  = '0;
            op_in    = OutOpNone;
            tmac_in  = '0;
            tip_in   = '0;
            retry_in = 1'b0;
            full_in  = 1'b0;
            if (job_ff.is_send) begin
               if (hit_ff) begin
                  act_in  = ActData;
                  dmac_in = hit_mac_ff;
               end else begin
                  act_in   = ActArpRequest;
                  dmac_in  = BroadcastMac;
                  op_in    = OutOpRequest;
                  tmac_in  = BroadcastMac;
                  tip_in   = job_ff.key_ip;
                  retry_in = 1'b1;
               end
            end else if (job_ff.is_arp) begin
               if (hit_ff) begin
                  wr_en = 1'b1;
               end else if (job_ff.for_us) begin
                  if (count_ff < CntW'(TABLE_DEPTH)) begin
                     wr_en    = 1'b1;
                     wr_addr  = count_ff[IdxW-1:0];
                     count_in = count_ff + 1'b1;
                  end else begin
                     full_in = 1'b1;
                  end
               end
               if (job_ff.for_us && job_ff.is_request) begin
                  act_in  = ActArpReply;
                  dmac_in = job_ff.frame_src_mac;
                  op_in   = OutOpReply;
                  tmac_in = job_ff.sender_mac;
                  tip_in  = job_ff.key_ip;
               end
            end else if (job_ff.deliver) begin
               act_in = ActDeliver;
            end
            full_out_in = full_in;
            state_in    = StOut;
         end
         StOut: begin
            if (rsp_pop) begin
               state_in = StIdle;
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      ip_rd_ff  <= ip_mem[rd_addr];
      mac_rd_ff <= mac_mem[rd_addr];
      if (wr_en) begin
         ip_mem[wr_addr]  <= wr_ip;
         mac_mem[wr_addr] <= wr_mac;
      end
      if (job_take) begin
         job_ff <= job;
      end
      hit_idx_ff  <= hit_idx_in;
      hit_mac_ff  <= hit_mac_in;
      act_ff      <= act_in;
      dmac_ff     <= dmac_in;
      op_ff       <= op_in;
      tmac_ff     <= tmac_in;
      tip_ff      <= tip_in;
      retry_ff    <= retry_in;
      full_ff     <= full_in;
      full_out_ff <= full_out_in;
      scan_ff     <= scan_in;
      hit_ff      <= hit_in;
      if (reset) begin
         state_ff <= StIdle;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

endmodule

>>> rtl/arc_csr.sv
module arc_csr
   import arc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [63:0] pwdata,
   output logic [63:0] prdata,
   output logic        pready,
   output logic [47:0] own_mac,
   output logic [31:0] own_ip
);

   localparam logic [3:0] AddrOwnMac = 4'h0;
   localparam logic [3:0] AddrOwnIp  = 4'h8;

   logic [47:0] mac_ff;
   logic [31:0] ip_ff;
   logic        wr;

   assign pready  = 1'b1;
   assign wr      = psel && penable && pwrite;
   assign own_mac = mac_ff;
   assign own_ip  = ip_ff;

   always_comb begin
      case (paddr)
         AddrOwnMac: prdata = {16'd0, mac_ff};
         AddrOwnIp:  prdata = {32'd0, ip_ff};
         default:    prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mac_ff <= '0;
         ip_ff  <= '0;
      end else if (wr) begin
         if (paddr == AddrOwnMac) begin
            mac_ff <= pwdata[47:0];
         end
         if (paddr == AddrOwnIp) begin
            ip_ff <= pwdata[31:0];
         end
      end
   end

endmodule

>>> rtl/arp_resolver_cache.sv
// Channel  | Ports                  | Direction | Transaction when
// request  | req_push / req_full    | in        | push high and full low
// response | rsp_pop / rsp_empty    | out       | pop high and empty low
// control  | csr_psel .. csr_pready | in/out    | psel, penable, pwrite, pready high
//
// The search walks the stored bindings one entry at a time: it issues an address,
// then checks the data from the single registered read port of the binding memory,
// and it stops at the first hit.
// A two-entry queue holds new transactions while the engine works or its
// result waits to be popped. Reset is synchronous and empties the table.
module arp_resolver_cache
   import arc_pkg::*;
#(
   parameter int unsigned TABLE_DEPTH = DefaultTableDepth
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_func,
   input  logic [31:0] req_dest_ip,
   input  logic [15:0] req_ether_type,
   input  logic [47:0] req_frame_dst_mac,
   input  logic [47:0] req_frame_src_mac,
   input  logic [15:0] req_arp_opcode,
   input  logic [47:0] req_arp_sender_mac,
   input  logic [31:0] req_arp_sender_ip,
   input  logic [31:0] req_arp_target_ip,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [2:0]  rsp_action,
   output logic [47:0] rsp_out_dst_mac,
   output logic [1:0]  rsp_out_arp_op,
   output logic [47:0] rsp_out_arp_target_mac,
   output logic [31:0] rsp_out_arp_target_ip,
   output logic        rsp_retry,
   output logic        rsp_table_full,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [63:0] csr_pwdata,
   output logic [63:0] csr_prdata,
   output logic        csr_pready
);

   logic [47:0] own_mac;
   logic [31:0] own_ip;
   logic        job_valid, job_take;
   job_type     job;

   arc_csr u_csr (
      .clock, .reset,
      .psel(csr_psel), .penable(csr_penable), .pwrite(csr_pwrite),
      .paddr(csr_paddr), .pwdata(csr_pwdata), .prdata(csr_prdata),
      .pready(csr_pready), .own_mac, .own_ip
   );

   arc_front u_front (
      .clock, .reset, .req_push, .req_full, .req_func, .req_dest_ip,
      .req_ether_type, .req_frame_dst_mac, .req_frame_src_mac,
      .req_arp_opcode, .req_arp_sender_mac, .req_arp_sender_ip,
      .req_arp_target_ip, .own_mac, .own_ip, .job_valid, .job, .job_take
   );

   arc_engine #(.TABLE_DEPTH(TABLE_DEPTH)) u_engine (
      .clock, .reset, .job_valid, .job, .job_take, .rsp_empty, .rsp_pop,
      .rsp_action, .rsp_out_dst_mac, .rsp_out_arp_op,
      .rsp_out_arp_target_mac, .rsp_out_arp_target_ip, .rsp_retry,
      .rsp_table_full
   );

endmodule
